// File: hdl/multilane_led_pulse_encoder_unit_macros.svh
// Assertion macros shared by the multilane LED pulse encoder modules.
`ifndef MULTILANE_LED_PULSE_ENCODER_UNIT_MACROS_SVH
`define MULTILANE_LED_PULSE_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTH
`define MLPE_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("immediate implication failed");
`define MLPE_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define MLPE_ASSERT_IMP(lbl, c, r, ante, cons)
`define MLPE_ASSERT_NXT(lbl, c, r, ante, cons)
`endif

`endif

// File: hdl/mlpe_pkg.sv
// Types and constants shared by the multilane LED pulse encoder.
package mlpe_pkg;

  localparam int BYTE_W         = 8;
  localparam int PULSES_PER_BIT = 8;
  localparam int WORDS_PER_ITEM = PULSES_PER_BIT * BYTE_W;
  localparam int IDX_W          = $clog2(WORDS_PER_ITEM);
  localparam int PULSE_W        = 16;
  localparam int LANES_W        = 5;
  localparam int CFG_DATA_W     = 8;
  localparam int CFG_IDX_W      = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LANES_W-1:0] lanes_t;
  typedef logic [BYTE_W-1:0]  pattern_t;

  localparam idx_t     LAST_IDX          = idx_t'(WORDS_PER_ITEM - 1);
  localparam lanes_t   LANES_RESET       = lanes_t'(1);
  localparam pattern_t PATTERN_ZERO_RST  = pattern_t'(192);
  localparam pattern_t PATTERN_ONE_RST   = pattern_t'(252);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LANES_IN_USE = 2'd0,
    CFG_PATTERN_ZERO = 2'd1,
    CFG_PATTERN_ONE  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] lane_bytes_low;
    logic [63:0] lane_bytes_high;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_word;
    logic               last_word;
  } out_item_t;

  typedef struct packed {
    logic fire;
    logic last;
  } emit_t;

endpackage

// File: hdl/mlpe_lane.sv
// One encoder lane: holds a data byte and produces its pulse for a word index.
module mlpe_lane #(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [7:0]          lane_byte,
  input  mlpe_pkg::lanes_t    lanes_in_use,
  input  mlpe_pkg::idx_t      pulse_idx,
  input  mlpe_pkg::pattern_t  pattern_zero,
  input  mlpe_pkg::pattern_t  pattern_one,
  output logic                pulse
);

  logic [7:0]         byte_r;
  logic               active_r;
  logic               data_bit;
  mlpe_pkg::pattern_t pat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= lanes_in_use > mlpe_pkg::lanes_t'(LANE);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= lane_byte;
    end
  end

  always_comb begin
    data_bit = byte_r[~pulse_idx[5:3]];
    pat      = data_bit ? pattern_one : pattern_zero;
    pulse    = active_r & pat[~pulse_idx[2:0]];
  end

endmodule

// File: hdl/mlpe_merge.sv
// Merge stage: gathers the lane pulses into one word and holds it in the output register.
`include "multilane_led_pulse_encoder_unit_macros.svh"

module mlpe_merge #(
  parameter int LANE_CNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LANE_CNT-1:0]  lane_pulses,
  input  mlpe_pkg::emit_t      ctl,
  input  logic                 out_ready,
  output logic                 out_valid,
  output mlpe_pkg::out_item_t  out_data,
  output logic                 can_take
);

  logic                        out_valid_r;
  mlpe_pkg::out_item_t         out_data_r;
  logic [mlpe_pkg::PULSE_W-1:0] word;

  always_comb begin
    word = '0;
    for (int i = 0; i < LANE_CNT; i++) begin
      word[i] = lane_pulses[i];
    end
  end

  assign can_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_data_r.pulse_word <= word;
      out_data_r.last_word  <= ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MLPE_ASSERT_IMP(a_fire_has_room, clk, rst_n, ctl.fire, can_take)
  `MLPE_ASSERT_NXT(a_fire_shows, clk, rst_n, ctl.fire, out_valid_r)
  `MLPE_ASSERT_NXT(a_stall_keeps, clk, rst_n, out_valid_r && !out_ready, out_valid_r)

endmodule

// File: hdl/multilane_led_pulse_encoder_unit.sv
// Top level of the multilane LED pulse encoder: lanes, word sequencer and merge stage.
//
// Usage: each item on the in_ channel carries one data byte per lane (lanes 0 to 7 in
// lane_bytes_low, 8 to 15 in lane_bytes_high). Every data bit, most significant first,
// becomes eight pulses taken from pattern_one or pattern_zero, and the block emits 64
// words on the out_ channel, one pulse per lane in each word, with last_word set on the
// 64th. Lanes at or above lanes_in_use give zero. The user must write lanes_in_use,
// pattern_zero and pattern_one through the cfg_ port only while no item is in flight;
// the block itself does not enforce this. Words leave through the merge stage output
// register, one word per cycle while the receiver does not stall, set by the six-bit
// word counter that steps all lanes together. The next item is accepted in the cycle
// the last word of the current one moves to the output register, so words stream
// without gaps. Reset restores the register defaults (one lane, patterns 192 and 252)
// and empties the pipeline. When the receiver stalls, the output register holds its word
// and the word counter waits; the next item waits until the last word has moved on.
`include "multilane_led_pulse_encoder_unit_macros.svh"

module multilane_led_pulse_encoder_unit #(
  parameter int MAX_LANES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mlpe_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mlpe_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [mlpe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mlpe_pkg::lanes_t   lanes_in_use_r;
  mlpe_pkg::pattern_t pattern_zero_r;
  mlpe_pkg::pattern_t pattern_one_r;

  logic               busy_r;
  logic               busy_nxt;
  mlpe_pkg::idx_t     index_r;
  mlpe_pkg::idx_t     index_nxt;

  logic               can_take;
  logic               fire;
  logic               last_idx;
  logic               in_accept;
  mlpe_pkg::emit_t    emit;
  logic [127:0]       bytes_all;
  logic [MAX_LANES-1:0] lane_pulses;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_in_use_r <= mlpe_pkg::LANES_RESET;
      pattern_zero_r <= mlpe_pkg::PATTERN_ZERO_RST;
      pattern_one_r  <= mlpe_pkg::PATTERN_ONE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlpe_pkg::CFG_LANES_IN_USE: lanes_in_use_r <= cfg_data[mlpe_pkg::LANES_W-1:0];
        mlpe_pkg::CFG_PATTERN_ZERO: pattern_zero_r <= cfg_data;
        mlpe_pkg::CFG_PATTERN_ONE:  pattern_one_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fire      = busy_r && can_take;
    last_idx  = index_r == mlpe_pkg::LAST_IDX;
    in_ready  = !busy_r || (fire && last_idx);
    in_accept = in_valid && in_ready;
    emit.fire = fire;
    emit.last = last_idx;
    bytes_all = {in_data.lane_bytes_high, in_data.lane_bytes_low};
  end

  always_comb begin
    busy_nxt  = busy_r;
    index_nxt = index_r;
    if (in_accept) begin
      busy_nxt  = 1'b1;
      index_nxt = '0;
    end else if (fire) begin
      index_nxt = index_r + mlpe_pkg::idx_t'(1);
      if (last_idx) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      index_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      index_r <= index_nxt;
    end
  end

  for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
    mlpe_lane #(
      .LANE(g)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .load         (in_accept),
      .lane_byte    (bytes_all[8*g +: 8]),
      .lanes_in_use (lanes_in_use_r),
      .pulse_idx    (index_r),
      .pattern_zero (pattern_zero_r),
      .pattern_one  (pattern_one_r),
      .pulse        (lane_pulses[g])
    );
  end

  mlpe_merge #(
    .LANE_CNT(MAX_LANES)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .lane_pulses (lane_pulses),
    .ctl         (emit),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .can_take    (can_take)
  );

  `MLPE_ASSERT_IMP(a_no_early_accept, clk, rst_n, busy_r && !last_idx, !in_ready)
  `MLPE_ASSERT_NXT(a_accept_starts, clk, rst_n, in_accept, busy_r && index_r == '0)
  `MLPE_ASSERT_NXT(a_last_ends, clk, rst_n, fire && last_idx && !in_accept, !busy_r)
  `MLPE_ASSERT_NXT(a_stall_holds, clk, rst_n, busy_r && !fire, $stable(index_r))

endmodule
